FILE: sv/fpha_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and count helpers of the fit-policy heap allocator.
package fpha_pkg;

    localparam int HEAP_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int GRANULE_BYTES    = 8;

    localparam int REQ_W    = 13;
    localparam int CNT_W    = 10;
    localparam int STATUS_W = 2;
    localparam int POLICY_W = 2;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [1:0] MARK_START = 2'b01;
    localparam logic [1:0] MARK_FREE  = 2'b10;
    localparam logic [1:0] MARK_NONE  = 2'b00;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_REL = 2'd2;

    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    localparam logic REG_FIT_POLICY = 1'b0;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
        return (c < COUNT_MAX) ? c + 1'b1 : c;
    endfunction

    function automatic logic [CNT_W-1:0] cnt_dec(input logic [CNT_W-1:0] c);
        return (c != '0) ? c - 1'b1 : c;
    endfunction

endpackage

FILE: sv/fpha_map_ram.sv
`timescale 1ns / 1ps
// Single-port granule map memory with registered read data.
module fpha_map_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [1:0]    wdata,
    output logic [1:0]    rdata
);

    logic [1:0] mem [DEPTH];
    logic [1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/fpha_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: map clear, chunk scan, read-modify-write commit and result register.
module fpha_ctrl #(
    parameter int HEAP_BYTES   = fpha_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = fpha_pkg::HEADER_BYTES_DEF,
    parameter int AW           = $clog2(HEAP_BYTES),
    parameter int GW           = $clog2(HEAP_BYTES / fpha_pkg::GRANULE_BYTES)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           opcode,
    input  logic [fpha_pkg::REQ_W-1:0]     request_bytes,
    input  logic [AW-1:0]                  release_address,
    input  logic [fpha_pkg::POLICY_W-1:0]  fit_policy,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [fpha_pkg::STATUS_W-1:0]  status,
    output logic [AW-1:0]                  data_address,
    output logic [fpha_pkg::CNT_W-1:0]     free_blocks,
    output logic [fpha_pkg::CNT_W-1:0]     occupied_blocks,
    output logic                           ram_we,
    output logic [GW-1:0]                  ram_addr,
    output logic [1:0]                     ram_wdata,
    input  logic [1:0]                     ram_rdata
);

    localparam int DEPTH = HEAP_BYTES / fpha_pkg::GRANULE_BYTES;
    localparam int SP    = HEAP_BYTES - HEADER_BYTES;
    localparam int LIM   = (SP + fpha_pkg::GRANULE_BYTES - 1) / fpha_pkg::GRANULE_BYTES;
    localparam int PW    = AW + 1;
    localparam int NW    = ((fpha_pkg::REQ_W + 1 > PW) ? fpha_pkg::REQ_W + 1 : PW) + 1;
    localparam int CW    = GW + 1;

    localparam logic [CW-1:0] CLR_LAST = CW'(DEPTH - 1);
    localparam logic [CW-1:0] SCAN_END = CW'(LIM);
    localparam logic [NW-1:0] HDR_N    = NW'(HEADER_BYTES);
    localparam logic [NW-1:0] SPLIT_N  = NW'(3 * HEADER_BYTES);
    localparam logic [PW-1:0] HDR_P    = PW'(HEADER_BYTES);
    localparam logic [PW-1:0] SP_P     = PW'(SP);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_W1   = 3'd4;
    localparam logic [2:0] S_W2   = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg;
    logic          rd_v_reg;
    logic [GW-1:0] sg_reg;

    logic          op_reg;
    logic [NW-1:0] need_reg, rt_reg;
    logic [GW-1:0] tg_reg;
    logic          aok_reg;

    logic          cur_free_reg;
    logic [GW-1:0] cur_pos_reg;
    logic          have_reg;
    logic [GW-1:0] best_reg;
    logic [NW-1:0] best_len_reg;
    logic [PW-1:0] best_nxt_reg;

    logic          prev_v_reg, prev_free_reg, nf_reg, nfree_reg;
    logic [1:0]    tmark_reg;
    logic [GW-1:0] nidx_reg;

    logic [fpha_pkg::CNT_W-1:0]    free_cnt_reg, occ_cnt_reg;
    logic [fpha_pkg::CNT_W-1:0]    free_cnt_next, occ_cnt_next;
    logic                          w2_en_next;
    logic [GW-1:0]                 w2_addr_reg, w2_addr_next;
    logic [1:0]                    w2_data_reg, w2_data_next;
    logic [fpha_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [AW-1:0]                 res_addr_reg, res_addr_next;

    logic                          out_valid_reg;
    logic [fpha_pkg::STATUS_W-1:0] status_reg;
    logic [AW-1:0]                 data_address_reg;
    logic [fpha_pkg::CNT_W-1:0]    free_blocks_reg, occupied_blocks_reg;

    // request rounding and release decode
    logic [NW-1:0] total_rnd;
    logic [AW-1:0] rel_off;
    logic          rel_ok;

    assign total_rnd = (NW'(request_bytes) + HDR_N + NW'(7)) & ~NW'(7);
    assign rel_off   = release_address - AW'(HEADER_BYTES);
    assign rel_ok    = (PW'(release_address) >= HDR_P) && (rel_off[2:0] == 3'd0);

    // chunk evaluation, shared by the scan and the closing step
    logic          ev_en;
    logic [PW-1:0] ev_nxt, ev_dat;
    logic [NW-1:0] ev_len;
    logic          ev_take;

    always_comb
    begin
        ev_en  = 1'b0;
        ev_nxt = SP_P;
        if (state_reg == S_SCAN)
        begin
            ev_en  = (op_reg == fpha_pkg::OP_ALLOC) && rd_v_reg && ram_rdata[0] && cur_free_reg;
            ev_nxt = PW'({sg_reg, 3'b000});
        end
        else if (state_reg == S_FIN)
        begin
            ev_en = (op_reg == fpha_pkg::OP_ALLOC) && cur_free_reg;
        end
        ev_dat = PW'({cur_pos_reg, 3'b000}) + HDR_P;
        ev_len = (ev_nxt > ev_dat) ? NW'(ev_nxt - ev_dat) : '0;
        ev_take = ev_en && (ev_len >= need_reg) &&
                  (!have_reg ||
                   ((fit_policy == fpha_pkg::POL_BEST) && (ev_len < best_len_reg)) ||
                   ((fit_policy == fpha_pkg::POL_WORST) && (ev_len > best_len_reg)));
    end

    // commit decisions
    logic [NW-1:0] tail_b;
    logic          split;
    logic          rel_valid, merge_n, merge_p;
    logic [fpha_pkg::CNT_W-1:0] fc_a, fc_b;

    always_comb
    begin
        tail_b    = NW'({best_reg, 3'b000}) + rt_reg;
        split     = (NW'(best_nxt_reg) > tail_b) && (NW'(best_nxt_reg) - tail_b > SPLIT_N);
        rel_valid = aok_reg && (tmark_reg == fpha_pkg::MARK_START);
        merge_n   = nf_reg && nfree_reg;
        merge_p   = prev_v_reg && prev_free_reg;
        fc_a      = fpha_pkg::cnt_inc(free_cnt_reg);
        fc_b      = merge_n ? fpha_pkg::cnt_dec(fc_a) : fc_a;

        free_cnt_next   = free_cnt_reg;
        occ_cnt_next    = occ_cnt_reg;
        w2_en_next      = 1'b0;
        w2_addr_next    = nidx_reg;
        w2_data_next    = fpha_pkg::MARK_NONE;
        res_status_next = fpha_pkg::ST_DONE;
        res_addr_next   = '0;
        ram_we          = 1'b0;
        ram_addr        = cnt_reg[GW-1:0];
        ram_wdata       = fpha_pkg::MARK_NONE;

        unique case (state_reg)
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_wdata = (cnt_reg == '0) ? (fpha_pkg::MARK_START | fpha_pkg::MARK_FREE)
                                            : fpha_pkg::MARK_NONE;
            end
            S_W1:
            begin
                if (op_reg == fpha_pkg::OP_ALLOC)
                begin
                    if (!have_reg)
                    begin
                        res_status_next = fpha_pkg::ST_NO_FIT;
                    end
                    else
                    begin
                        ram_we        = 1'b1;
                        ram_addr      = best_reg;
                        ram_wdata     = fpha_pkg::MARK_START;
                        occ_cnt_next  = fpha_pkg::cnt_inc(occ_cnt_reg);
                        res_addr_next = AW'(PW'({best_reg, 3'b000}) + HDR_P);
                        if (split)
                        begin
                            w2_en_next   = 1'b1;
                            w2_addr_next = tail_b[GW+2:3];
                            w2_data_next = fpha_pkg::MARK_START | fpha_pkg::MARK_FREE;
                        end
                        else
                        begin
                            free_cnt_next = fpha_pkg::cnt_dec(free_cnt_reg);
                        end
                    end
                end
                else
                begin
                    if (!rel_valid)
                    begin
                        res_status_next = fpha_pkg::ST_BAD_REL;
                    end
                    else
                    begin
                        ram_we        = 1'b1;
                        ram_addr      = tg_reg;
                        ram_wdata     = merge_p ? fpha_pkg::MARK_NONE
                                                : (fpha_pkg::MARK_START | fpha_pkg::MARK_FREE);
                        occ_cnt_next  = fpha_pkg::cnt_dec(occ_cnt_reg);
                        free_cnt_next = merge_p ? fpha_pkg::cnt_dec(fc_b) : fc_b;
                        w2_en_next    = merge_n;
                    end
                end
            end
            S_W2:
            begin
                ram_we    = 1'b1;
                ram_addr  = w2_addr_reg;
                ram_wdata = w2_data_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:  if (cnt_reg == CLR_LAST) state_next = S_IDLE;
            S_IDLE: if (in_valid) state_next = S_SCAN;
            S_SCAN: if (cnt_reg == SCAN_END && !rd_v_reg) state_next = S_FIN;
            S_FIN:  state_next = S_W1;
            S_W1:   state_next = w2_en_next ? S_W2 : S_DONE;
            S_W2:   state_next = S_DONE;
            S_DONE: if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            cnt_reg       <= '0;
            rd_v_reg      <= 1'b0;
            free_cnt_reg  <= fpha_pkg::CNT_W'(1);
            occ_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            free_cnt_reg <= free_cnt_next;
            occ_cnt_reg  <= occ_cnt_next;
            if (state_reg == S_CLR || state_reg == S_SCAN)
            begin
                rd_v_reg <= (state_reg == S_SCAN) && (cnt_reg < SCAN_END);
                if (!(state_reg == S_SCAN && cnt_reg == SCAN_END))
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            else
            begin
                cnt_reg  <= '0;
                rd_v_reg <= 1'b0;
            end
            if (state_reg == S_DONE && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sg_reg <= cnt_reg[GW-1:0];
        if (state_reg == S_IDLE)
        begin
            op_reg        <= opcode;
            rt_reg        <= total_rnd;
            need_reg      <= total_rnd - HDR_N;
            tg_reg        <= rel_off[AW-1:3];
            aok_reg       <= rel_ok;
            cur_free_reg  <= 1'b0;
            cur_pos_reg   <= '0;
            have_reg      <= 1'b0;
            best_reg      <= '0;
            best_len_reg  <= '0;
            best_nxt_reg  <= SP_P;
            prev_v_reg    <= 1'b0;
            prev_free_reg <= 1'b0;
            tmark_reg     <= fpha_pkg::MARK_NONE;
            nf_reg        <= 1'b0;
            nfree_reg     <= 1'b0;
            nidx_reg      <= '0;
        end
        if (ev_take)
        begin
            have_reg     <= 1'b1;
            best_reg     <= cur_pos_reg;
            best_len_reg <= ev_len;
            best_nxt_reg <= ev_nxt;
        end
        if (state_reg == S_SCAN && rd_v_reg && ram_rdata[0])
        begin
            cur_free_reg <= ram_rdata[1];
            cur_pos_reg  <= sg_reg;
            if (sg_reg < tg_reg)
            begin
                prev_v_reg    <= 1'b1;
                prev_free_reg <= ram_rdata[1];
            end
            if (sg_reg > tg_reg && !nf_reg)
            begin
                nf_reg    <= 1'b1;
                nfree_reg <= ram_rdata[1];
                nidx_reg  <= sg_reg;
            end
        end
        if (state_reg == S_SCAN && rd_v_reg && sg_reg == tg_reg)
        begin
            tmark_reg <= ram_rdata;
        end
        if (state_reg == S_W1)
        begin
            w2_addr_reg    <= w2_addr_next;
            w2_data_reg    <= w2_data_next;
            res_status_reg <= res_status_next;
            res_addr_reg   <= res_addr_next;
        end
        if (state_reg == S_DONE && (!out_valid_reg || out_ready))
        begin
            status_reg          <= res_status_reg;
            data_address_reg    <= res_addr_reg;
            free_blocks_reg     <= free_cnt_reg;
            occupied_blocks_reg <= occ_cnt_reg;
        end
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign data_address    = data_address_reg;
    assign free_blocks     = free_blocks_reg;
    assign occupied_blocks = occupied_blocks_reg;

endmodule

FILE: sv/fit_policy_heap_allocator_top.sv
`timescale 1ns / 1ps
// Fit-policy heap allocator: chunk map over a fixed arena, allocate and free.
//
// Input channel (in_valid/in_ready) takes one word per operation: opcode 0
// allocates request_bytes, opcode 1 frees the chunk whose data starts at
// release_address. Each word gives exactly one result word on the output
// channel (out_valid/out_ready): status, data_address, free_blocks and
// occupied_blocks.
// Every operation scans the granule map in one pass, one granule per cycle
// through the single map RAM port, then writes back up to two entries.
// With the default arena the scan covers 509 granules, then come close,
// commit, optional second write and result load.
// One operation is in flight at a time; in_ready is high only when idle, so
// a new word is taken only after the previous one has been worked through.
// The result sits in an output register; a stalled receiver holds it and
// the next word may be accepted and worked on meanwhile, waiting only at
// its own result if the earlier one is still not taken.
// After reset the map is cleared one entry per cycle, all HEAP_BYTES/8
// entries (512 by default), before the first word is accepted. The
// fit_policy register resets to first fit; the user is bound to have it
// written only with no word in flight, as the block does not enforce this.
module fit_policy_heap_allocator_top #(
    parameter int HEAP_BYTES   = fpha_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = fpha_pkg::HEADER_BYTES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 opcode,
    input  logic [fpha_pkg::REQ_W-1:0]           request_bytes,
    input  logic [$clog2(HEAP_BYTES)-1:0]        release_address,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [fpha_pkg::STATUS_W-1:0]        status,
    output logic [$clog2(HEAP_BYTES)-1:0]        data_address,
    output logic [fpha_pkg::CNT_W-1:0]           free_blocks,
    output logic [fpha_pkg::CNT_W-1:0]           occupied_blocks,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [fpha_pkg::APB_AW-1:0]          paddr,
    input  logic [fpha_pkg::APB_DW-1:0]          pwdata,
    output logic [fpha_pkg::APB_DW-1:0]          prdata,
    output logic                                 pready
);

    localparam int AW    = $clog2(HEAP_BYTES);
    localparam int DEPTH = HEAP_BYTES / fpha_pkg::GRANULE_BYTES;
    localparam int GW    = $clog2(DEPTH);

    logic [fpha_pkg::POLICY_W-1:0] fit_policy_reg;
    logic                          ram_we;
    logic [GW-1:0]                 ram_addr;
    logic [1:0]                    ram_wdata, ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg <= fpha_pkg::POL_FIRST;
        end
        else if (psel && penable && pwrite && paddr[2] == fpha_pkg::REG_FIT_POLICY)
        begin
            fit_policy_reg <= pwdata[fpha_pkg::POLICY_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == fpha_pkg::REG_FIT_POLICY)
                    ? fpha_pkg::APB_DW'(fit_policy_reg) : '0;

    fpha_map_ram #(
        .DEPTH (DEPTH),
        .AW    (GW)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    fpha_ctrl #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .AW           (AW),
        .GW           (GW)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .request_bytes   (request_bytes),
        .release_address (release_address),
        .fit_policy      (fit_policy_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .data_address    (data_address),
        .free_blocks     (free_blocks),
        .occupied_blocks (occupied_blocks),
        .ram_we          (ram_we),
        .ram_addr        (ram_addr),
        .ram_wdata       (ram_wdata),
        .ram_rdata       (ram_rdata)
    );

endmodule
